### hdl/tfrp_pkg.sv
// Shared types, event and mode codes and byte helpers for the text frame
// record parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfrp_pkg;

  localparam int unsigned NameCapacityDefault  = 9;
  localparam int unsigned ValueCapacityDefault = 33;

  // parse modes
  localparam logic [2:0] ModeIdle  = 3'd0;
  localparam logic [2:0] ModeBegin = 3'd1;
  localparam logic [2:0] ModeName  = 3'd2;
  localparam logic [2:0] ModeValue = 3'd3;
  localparam logic [2:0] ModeCheck = 3'd4;

  // event kinds
  localparam logic [2:0] EvNone  = 3'd0;
  localparam logic [2:0] EvName  = 3'd1;
  localparam logic [2:0] EvValue = 3'd2;
  localparam logic [2:0] EvDone  = 3'd3;
  localparam logic [2:0] EvDrop  = 3'd4;
  localparam logic [2:0] EvGood  = 3'd5;
  localparam logic [2:0] EvBad   = 3'd6;

  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [3:0] TagLen  = 4'd8;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] sum;
    logic [3:0] name_len;
    logic [5:0] val_len;
    logic       name_chk;
  } tfrp_state_t;

  function automatic logic [7:0] upcase(input logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7a) begin
      return b - 8'd32;
    end
    return b;
  endfunction

  // "CHECKSUM"
  function automatic logic [7:0] check_tag(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h43;
      3'd1:    c = 8'h48;
      3'd2:    c = 8'h45;
      3'd3:    c = 8'h43;
      3'd4:    c = 8'h4b;
      3'd5:    c = 8'h53;
      3'd6:    c = 8'h55;
      default: c = 8'h4d;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/tfrp_step.sv
// Next-state and event logic for one received byte.
// Depends on tfrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfrp_step
  import tfrp_pkg::*;
#(
  parameter int unsigned NameCapacity  = NameCapacityDefault,
  parameter int unsigned ValueCapacity = ValueCapacityDefault
) (
  input  tfrp_state_t state_i,
  input  logic [7:0]  rx_byte_i,
  output tfrp_state_t state_o,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_o
);

  localparam logic [3:0] NameCap  = 4'(NameCapacity);
  localparam logic [5:0] ValueCap = 6'(ValueCapacity);
  localparam bit TagFits = (NameCapacity > 8);

  logic [7:0] b;
  logic       tag_hit;

  assign b       = upcase(rx_byte_i);
  assign tag_hit = (b == check_tag(state_i.name_len[2:0]));

  always_comb begin
    state_o     = state_i;
    kind_o      = EvNone;
    byte_o      = 8'd0;
    state_o.sum = state_i.sum + rx_byte_i;

    if (rx_byte_i == ChColon && state_i.mode != ModeCheck) begin
      // abort: colon is not summed
      state_o.sum  = state_i.sum;
      state_o.mode = ModeIdle;
    end else begin
      unique case (state_i.mode)
        ModeBegin: begin
          state_o.name_len = 4'd1;
          state_o.name_chk = (b == check_tag(3'd0));
          state_o.mode     = ModeName;
          kind_o           = EvName;
          byte_o           = b;
        end
        ModeName: begin
          if (b == ChTab) begin
            if (state_i.name_chk && state_i.name_len == TagLen && TagFits) begin
              state_o.mode = ModeCheck;
            end else begin
              state_o.val_len = 6'd0;
              state_o.mode    = ModeValue;
            end
          end else if (state_i.name_len < NameCap) begin
            state_o.name_chk = (state_i.name_len < TagLen) ? (state_i.name_chk && tag_hit)
                                                           : 1'b0;
            state_o.name_len = state_i.name_len + 4'd1;
            kind_o           = EvName;
            byte_o           = b;
          end
        end
        ModeValue: begin
          if (b == ChLf) begin
            kind_o       = (state_i.val_len < ValueCap) ? EvDone : EvDrop;
            state_o.mode = ModeBegin;
          end else if (b != ChCr && state_i.val_len < ValueCap) begin
            state_o.val_len = state_i.val_len + 6'd1;
            kind_o          = EvValue;
            byte_o          = b;
          end
        end
        ModeCheck: begin
          kind_o       = (state_o.sum == 8'd0) ? EvGood : EvBad;
          state_o.sum  = 8'd0;
          state_o.mode = ModeIdle;
        end
        default: begin
          // idle and unused codes
          state_o.mode = (b == ChLf) ? ModeBegin : ModeIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/text_frame_record_parser_core.sv
// Top level of the text frame record parser: input register, parse step,
// event register. Depends on tfrp_pkg and tfrp_step.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries one received byte per beat
//   on rx_byte_i. Output channel out_valid_o / out_ready_i carries exactly one
//   event per input beat on event_kind_o / event_byte_o, in arrival order.
//   An event is presented from the event register: its byte lands in the
//   input register when it is accepted, and the parse step result lands in
//   the event register when that register advances.
//   Throughput: one byte per cycle while the receiver takes every event, as
//   the parse step makes each byte's mode update to the parser state.
//   When the receiver stalls, the event register holds and the input
//   register still takes one more byte; further bytes wait until the event
//   is taken. in_ready_o stays high whenever no event is pending.
//   Reset (rst_ni low, asynchronous) empties both registers and returns the
//   parser to idle with a zero checksum; the first record starts after the
//   next newline.
`timescale 1ns / 1ps
`default_nettype none

module text_frame_record_parser_core
  import tfrp_pkg::*;
#(
  parameter int unsigned NameCapacity  = NameCapacityDefault,
  parameter int unsigned ValueCapacity = ValueCapacityDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_kind_o,
  output logic [7:0] event_byte_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [7:0]  byte_q;
  tfrp_state_t state_q, state_d;
  logic [2:0]  kind_d;
  logic [7:0]  byte_d;
  logic        advance;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  tfrp_step #(
    .NameCapacity (NameCapacity),
    .ValueCapacity(ValueCapacity)
  ) u_step (
    .state_i  (state_q),
    .rx_byte_i(in_byte_q),
    .state_o  (state_d),
    .kind_o   (kind_d),
    .byte_o   (byte_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: ModeIdle, sum: 8'd0, name_len: 4'd0, val_len: 6'd0,
                       name_chk: 1'b0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && in_valid_q) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign event_byte_o = byte_q;

endmodule

`default_nettype wire

### hdl/tfrp_checker.sv
// Port-level checks for text_frame_record_parser_core, bound to the top.
// Depends on tfrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfrp_checker
  import tfrp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] event_kind_o,
  input logic [7:0] event_byte_o
);

  // stalled event beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o)
                                    && $stable(event_byte_o))
    else $error("event changed while stalled");

  // no pending event means the input side is open
  a_ready_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no pending event");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_kind_o <= EvBad)
    else $error("event kind out of range");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != EvName && event_kind_o != EvValue
      |-> event_byte_o == 8'd0)
    else $error("nonzero byte on a non-byte event");

  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EvName || event_kind_o == EvValue)
      |-> !(event_byte_o >= 8'h61 && event_byte_o <= 8'h7a))
    else $error("lowercase byte emitted");

endmodule

bind text_frame_record_parser_core tfrp_checker u_tfrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .event_kind_o(event_kind_o),
  .event_byte_o(event_byte_o)
);

`default_nettype wire
